>>> design/assert_macros.svh
// Assertion macros shared by the checked RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked implication, disabled while rst_n is low.
`define SWS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Same, with the consequent checked in the cycle after the antecedent.
`define SWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWS_ASSERT_IMPL(label, ante, cons, msg)
`define SWS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/sws_pkg.sv
// Shared types, codes and widths for the sorted window statistics block.
package sws_pkg;

  localparam int SWS_WINDOW_DEPTH = 64;
  localparam int SAMPLE_W         = 32;
  localparam int STAT_W           = 38;
  localparam int SEL_W            = 3;

  // statistic_select codes
  localparam logic [SEL_W-1:0] STAT_MEDIAN = 3'd0;
  localparam logic [SEL_W-1:0] STAT_MIN    = 3'd1;
  localparam logic [SEL_W-1:0] STAT_MAX    = 3'd2;
  localparam logic [SEL_W-1:0] STAT_MEAN   = 3'd3;
  localparam logic [SEL_W-1:0] STAT_RANGE  = 3'd4;
  localparam logic [SEL_W-1:0] STAT_MODE   = 3'd5;
  localparam logic [SEL_W-1:0] STAT_SUM    = 3'd6;

  // result source codes
  localparam int SRC_W = 3;
  localparam logic [SRC_W-1:0] SRC_FIRST  = 3'd0;
  localparam logic [SRC_W-1:0] SRC_LATEST = 3'd1;
  localparam logic [SRC_W-1:0] SRC_RANGE  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_SUM    = 3'd3;
  localparam logic [SRC_W-1:0] SRC_BEST   = 3'd4;
  localparam logic [SRC_W-1:0] SRC_RAM    = 3'd5;
  localparam logic [SRC_W-1:0] SRC_DIV    = 3'd6;

  // running sum is exact, and never narrower than the result
  function automatic int sws_sum_width(input int depth);
    int w;
    w = SAMPLE_W + 1 + $clog2(depth);
    return (w > STAT_W) ? w : STAT_W;
  endfunction

  typedef struct packed {
    logic             accept;     // sample word taken this cycle
    logic             div_start;
    logic             load;       // capture result, clear window
    logic [SRC_W-1:0] src;
  } sws_cmd_t;

  typedef struct packed {
    logic [SEL_W-1:0] stat_sel;
    logic             mode_found;
    logic             div_done;
    logic             out_busy;
  } sws_stat_t;

endpackage

>>> design/sws_in_if.sv
// Sample input channel.
interface sws_in_if import sws_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

>>> design/sws_out_if.sv
// Result output channel.
interface sws_out_if import sws_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [STAT_W-1:0] stat_value;
  logic                     too_many;

  modport source (output valid, output stat_value, output too_many, input ready);
  modport sink   (input valid, input stat_value, input too_many, output ready);
endinterface

>>> design/sorted_window_statistics.sv
// Top level of the sorted window statistics block.
//
//   channel  dir  words                          handshake
//   in_ch    in   sample (s32 Q16.16), last      valid/ready
//   out_ch   out  stat_value (s38), too_many     valid/ready
//   cfg      in   cfg_data = statistic_select    cfg_we, no read-back
//
// Samples are taken one per cycle. After the word with last set the input stalls:
// min, max, range, sum and a found mode are loaded straight from the select state, median
// after a RAM read state, mean and mode fallback after the bit-serial divider.
// The result register holds until taken; the next window streams in meanwhile, and
// after its closing word the input stalls until that register is free.
// Reset is synchronous; no clearing pass.
`include "assert_macros.svh"
module sorted_window_statistics import sws_pkg::*; #(
  parameter int WINDOW_DEPTH = SWS_WINDOW_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  sws_in_if.sink           in_ch,
  sws_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [SEL_W-1:0] cfg_data
);
  sws_cmd_t  cmd;
  sws_stat_t stat;
  logic      in_take;

  assign in_take = in_ch.valid && in_ch.ready;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sws_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_sample      (in_ch.sample),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_stat_value (out_ch.stat_value),
    .out_too_many   (out_ch.too_many)
  );

  // window close stops input for at least the cycle after it
  `SWS_ASSERT_NEXT(a_close_stalls, in_take && in_ch.last, !in_ch.ready, "input taken after close")
  // a new result word only comes out of a compute state
  `SWS_ASSERT_IMPL(a_result_after_close, $rose(out_ch.valid), $past(!in_ch.ready), "stray result")
  // no result capture while a sample word is being taken
  `SWS_ASSERT_IMPL(a_load_excl_accept, cmd.load, !cmd.accept, "result load during sample accept")
endmodule

>>> design/sws_ram.sv
// Generic single write port RAM with registered read.
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/sws_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
module sws_div import sws_pkg::*; #(
  parameter int DIVIDEND_W = 39,
  parameter int DIVISOR_W  = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic        [DIVISOR_W-1:0]  divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);
  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVIDEND_W-1:0] quot_r, quot_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  assign trial     = {rem_r, quot_r[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DIVIDEND_W);
      neg_nxt  = dividend[DIVIDEND_W-1];
      quot_nxt = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DIVIDEND_W-2:0], fits};
      rem_nxt  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(~quot_r + 1'b1) : $signed(quot_r);
endmodule

>>> design/sws_ctrl.sv
// Window controller: accumulate, then pick and produce the statistic.
module sws_ctrl import sws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  sws_stat_t stat,
  output sws_cmd_t  cmd
);
  localparam logic [1:0] ST_ACCUM  = 2'd0;
  localparam logic [1:0] ST_SELECT = 2'd1;
  localparam logic [1:0] ST_MED    = 2'd2;
  localparam logic [1:0] ST_DIV    = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load      = 1'b0;
    cmd.src       = SRC_FIRST;
    case (state_r)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        // hold until the previous result word has left
        if (!stat.out_busy) begin
          case (stat.stat_sel)
            STAT_MIN: begin
              cmd.load  = 1'b1;
              cmd.src   = SRC_FIRST;
              state_nxt = ST_ACCUM;
            end
            STAT_MAX: begin
              cmd.load  = 1'b1;
              cmd.src   = SRC_LATEST;
              state_nxt = ST_ACCUM;
            end
            STAT_RANGE: begin
              cmd.load  = 1'b1;
              cmd.src   = SRC_RANGE;
              state_nxt = ST_ACCUM;
            end
            STAT_SUM: begin
              cmd.load  = 1'b1;
              cmd.src   = SRC_SUM;
              state_nxt = ST_ACCUM;
            end
            STAT_MODE: begin
              if (stat.mode_found) begin
                cmd.load  = 1'b1;
                cmd.src   = SRC_BEST;
                state_nxt = ST_ACCUM;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt     = ST_DIV;
              end
            end
            STAT_MEAN: begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
            default: begin
              // median and the unused code: RAM read of count/2 is in flight
              state_nxt = ST_MED;
            end
          endcase
        end
      end
      ST_MED: begin
        cmd.load  = 1'b1;
        cmd.src   = SRC_RAM;
        state_nxt = ST_ACCUM;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.load  = 1'b1;
          cmd.src   = SRC_DIV;
          state_nxt = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

>>> design/sws_dp.sv
// Datapath: sample store, running statistics, divider and result register.
module sws_dp import sws_pkg::*; #(
  parameter int WINDOW_DEPTH = SWS_WINDOW_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [SEL_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  sws_cmd_t                   cmd,
  output sws_stat_t                  stat,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [STAT_W-1:0]   out_stat_value,
  output logic                       out_too_many
);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = sws_sum_width(WINDOW_DEPTH);
  localparam int EXT_W  = SUM_W - SAMPLE_W;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - STAT_W + 1){1'b0}}, {(STAT_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - STAT_W + 1){1'b1}}, {(STAT_W - 1){1'b0}}};

  logic [SEL_W-1:0]           sel_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] first_r, latest_r, run_val_r, best_val_r;
  logic [CNT_W-1:0]           run_len_r, best_len_r;
  logic                       ovf_r;
  logic                       out_valid_r;
  logic signed [STAT_W-1:0]   out_value_r;
  logic                       out_too_many_r;

  logic                       full;
  logic                       store;
  logic [CNT_W-1:0]           run_inc;
  logic [CNT_W-1:0]           half_cnt;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       div_done;
  logic signed [SUM_W-1:0]    div_quot;
  logic signed [SUM_W-1:0]    samp_ext, first_ext, latest_ext, best_ext, ram_ext;
  logic signed [SUM_W-1:0]    pick;
  logic signed [STAT_W-1:0]   pick_sat;

  assign full     = (count_r == CNT_W'(WINDOW_DEPTH));
  assign store    = cmd.accept && !full;
  assign run_inc  = run_len_r + 1'b1;
  assign half_cnt = count_r >> 1;

  assign samp_ext   = {{EXT_W{in_sample[SAMPLE_W-1]}}, in_sample};
  assign first_ext  = {{EXT_W{first_r[SAMPLE_W-1]}}, first_r};
  assign latest_ext = {{EXT_W{latest_r[SAMPLE_W-1]}}, latest_r};
  assign best_ext   = {{EXT_W{best_val_r[SAMPLE_W-1]}}, best_val_r};
  assign ram_ext    = {{EXT_W{ram_rdata[SAMPLE_W-1]}}, ram_rdata};

  sws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_sample),
    .raddr (half_cnt[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  sws_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    case (cmd.src)
      SRC_FIRST:  pick = first_ext;
      SRC_LATEST: pick = latest_ext;
      SRC_RANGE:  pick = latest_ext - first_ext;
      SRC_SUM:    pick = sum_r;
      SRC_BEST:   pick = best_ext;
      SRC_RAM:    pick = ram_ext;
      SRC_DIV:    pick = div_quot;
      default:    pick = '0;
    endcase
    if (pick > SAT_HI) begin
      pick_sat = SAT_HI[STAT_W-1:0];
    end else if (pick < SAT_LO) begin
      pick_sat = SAT_LO[STAT_W-1:0];
    end else begin
      pick_sat = pick[STAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= STAT_MEDIAN;
      count_r     <= '0;
      sum_r       <= '0;
      first_r     <= '0;
      latest_r    <= '0;
      run_val_r   <= '0;
      run_len_r   <= '0;
      best_val_r  <= '0;
      best_len_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sel_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        sum_r       <= '0;
        first_r     <= '0;
        latest_r    <= '0;
        run_val_r   <= '0;
        run_len_r   <= '0;
        best_val_r  <= '0;
        best_len_r  <= '0;
        ovf_r       <= 1'b0;
      end else if (cmd.accept) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          if (count_r == '0) begin
            first_r   <= in_sample;
            run_val_r <= in_sample;
            run_len_r <= CNT_W'(1);
          end else if (in_sample == run_val_r) begin
            run_len_r <= run_inc;
            // first longest run wins: strictly longer only
            if (run_inc > best_len_r) begin
              best_val_r <= run_val_r;
              best_len_r <= run_inc;
            end
          end else begin
            run_val_r <= in_sample;
            run_len_r <= CNT_W'(1);
          end
          latest_r <= in_sample;
          sum_r    <= sum_r + samp_ext;
          count_r  <= count_r + 1'b1;
        end
      end
    end
    if (cmd.load) begin
      out_value_r    <= pick_sat;
      out_too_many_r <= ovf_r;
    end
  end

  assign stat.stat_sel   = sel_r;
  assign stat.mode_found = (best_len_r >= CNT_W'(2));
  assign stat.div_done   = div_done;
  assign stat.out_busy   = out_valid_r;

  assign out_valid      = out_valid_r;
  assign out_stat_value = out_value_r;
  assign out_too_many   = out_too_many_r;
endmodule
